// ----- rtl/siol_pkg.sv -----
// Package for the sorted interval overlap lookup.
// Shared types, codes and defaults; no dependencies.
package siol_pkg;

	localparam int SIOL_TABLE_DEPTH = 1024;
	localparam int REF_W = 15;
	localparam int POS_W = 32;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_QUERY  = 1'b1
	} req_kind_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_BAD_RANGE = 2'd2,
		STATUS_BAD_REF   = 2'd3
	} status_t;

	// What the bisection is currently looking for
	typedef enum logic [1:0] {
		MODE_INS_POS,
		MODE_SEG_LO,
		MODE_SEG_HI,
		MODE_PROBE
	} search_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH_RD,
		ST_SEARCH_EV,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_PLACE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [REF_W-1:0] ref_num;
		logic [POS_W-1:0] first;
		logic [POS_W-1:0] last;
	} entry_t;

	// Flags from the comparator, key against one stored entry
	typedef struct packed {
		logic ref_lt;
		logic ref_eq;
		logic first_le_start;
		logic end_lt_first;
		logic start_gt_last;
	} cmp_t;

endpackage

// ----- rtl/siol_req_if.sv -----
// Request channel: valid/ready handshake with insert or query payload.
// Depends on nothing.
interface siol_req_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic signed [15:0] ref_id;
	logic        [31:0] range_start;
	logic        [31:0] range_end;

	modport source (output valid, req_type, ref_id, range_start, range_end, input ready);
	modport sink   (input valid, req_type, ref_id, range_start, range_end, output ready);
endinterface

// ----- rtl/siol_rsp_if.sv -----
// Response channel: valid/ready handshake with hit flag and status.
// Depends on nothing.
interface siol_rsp_if;
	logic       valid;
	logic       ready;
	logic       overlap_found;
	logic [1:0] status;

	modport source (output valid, overlap_found, status, input ready);
	modport sink   (input valid, overlap_found, status, output ready);
endinterface

// ----- rtl/siol_mem.sv -----
// Interval table storage: one write port, one read port, registered read.
// Depends on siol_pkg.
module siol_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  siol_pkg::entry_t wdata,
	input  logic [AW-1:0]    raddr,
	output siol_pkg::entry_t rdata
);
	import siol_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/siol_cmp.sv -----
// Shared comparator: key interval and reference against one table entry.
// Depends on siol_pkg.
module siol_cmp (
	input  logic [siol_pkg::REF_W-1:0] key_ref,
	input  logic [siol_pkg::POS_W-1:0] key_start,
	input  logic [siol_pkg::POS_W-1:0] key_end,
	input  siol_pkg::entry_t           ent,
	output siol_pkg::cmp_t             flags
);
	import siol_pkg::*;

	always_comb begin
		flags.ref_lt         = ent.ref_num < key_ref;
		flags.ref_eq         = ent.ref_num == key_ref;
		flags.first_le_start = ent.first <= key_start;
		flags.end_lt_first   = key_end < ent.first;
		flags.start_gt_last  = key_start > ent.last;
	end

endmodule

// ----- rtl/sorted_interval_overlap_lookup.sv -----
// Sorted interval overlap lookup. One item at a time; ready is high only when idle.
// Every probe goes through one read port and one shared comparator: first the address,
// then the compare. A query runs three bisections: the start of its reference's segment,
// the end of it, then the overlap search. An insert bisects for its slot, then moves every
// later entry up by one, each with a read and then a write. Rejected inserts and queries
// with a negative reference go straight to the finish state. A finished result sits in
// the output register, and the next item is taken meanwhile.
module sorted_interval_overlap_lookup #(
	parameter int TABLE_DEPTH = siol_pkg::SIOL_TABLE_DEPTH
) (
	input logic       clk,
	input logic       arst_n,
	siol_req_if.sink  req,
	siol_rsp_if.source rsp
);
	import siol_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

	state_t        state_q, state_d;
	search_mode_t  mode_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] lo_q, hi_q, seg_lo_q, idx_q;
	logic [REF_W-1:0] key_ref_q;
	logic [POS_W-1:0] key_start_q, key_end_q;
	logic          res_hit_q;
	status_t       res_status_q;
	logic          rsp_valid_q;
	logic          rsp_hit_q;
	logic [1:0]    rsp_status_q;

	logic [CW:0]   mid_sum;
	logic [CW-1:0] mid;
	logic [CW-1:0] idx_m1;
	logic          search_done;
	logic          accept;
	logic          rsp_free;
	logic          goes_before;

	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	entry_t        mem_wdata, mem_rdata, key_entry;
	cmp_t          flags;

	assign mid_sum     = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid         = mid_sum[CW:1];
	assign idx_m1      = idx_q - CW'(1);
	assign search_done = !(lo_q < hi_q);
	assign accept      = req.valid && req.ready;
	assign rsp_free    = !rsp_valid_q || rsp.ready;
	assign key_entry   = '{ref_num: key_ref_q, first: key_start_q, last: key_end_q};

	siol_mem #(
		.DEPTH(TABLE_DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	siol_cmp u_cmp (
		.key_ref  (key_ref_q),
		.key_start(key_start_q),
		.key_end  (key_end_q),
		.ent      (mem_rdata),
		.flags    (flags)
	);

	// Monotone predicate of the bounding searches: entry sorts before the target.
	// In the probe, key end below entry first wins over key start above entry last.
	always_comb begin
		unique case (mode_q)
			MODE_INS_POS: goes_before = flags.ref_lt || (flags.ref_eq && flags.first_le_start);
			MODE_SEG_LO:  goes_before = flags.ref_lt;
			MODE_SEG_HI:  goes_before = flags.ref_lt || flags.ref_eq;
			MODE_PROBE:   goes_before = flags.start_gt_last && !flags.end_lt_first;
			default:      goes_before = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = mem_rdata;
		mem_raddr = mid[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.req_type == REQ_QUERY) begin
						state_d = req.ref_id[15] ? ST_FINISH : ST_SEARCH_RD;
					end else if (count_q == FULL_COUNT || req.range_end < req.range_start
							|| req.ref_id[15]) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_SEARCH_RD;
					end
				end
			end
			ST_SEARCH_RD: begin
				if (search_done) begin
					unique case (mode_q)
						MODE_INS_POS: state_d = (lo_q < count_q) ? ST_SHIFT_RD : ST_PLACE;
						MODE_PROBE:   state_d = ST_FINISH;
						default:      state_d = ST_SEARCH_RD;
					endcase
				end else begin
					state_d = ST_SEARCH_EV;
				end
			end
			ST_SEARCH_EV: begin
				if (mode_q == MODE_PROBE && !flags.end_lt_first && !flags.start_gt_last) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_SEARCH_RD;
				end
			end
			ST_SHIFT_RD: begin
				mem_raddr = idx_m1[AW-1:0];
				state_d   = ST_SHIFT_WR;
			end
			ST_SHIFT_WR: begin
				mem_we  = 1'b1;
				state_d = (idx_m1 == lo_q) ? ST_PLACE : ST_SHIFT_RD;
			end
			ST_PLACE: begin
				mem_we    = 1'b1;
				mem_waddr = lo_q[AW-1:0];
				mem_wdata = key_entry;
				state_d   = ST_FINISH;
			end
			ST_FINISH: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Search bounds, key and pending result
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				key_ref_q    <= req.ref_id[REF_W-1:0];
				key_start_q  <= req.range_start;
				key_end_q    <= req.range_end;
				lo_q         <= '0;
				hi_q         <= count_q;
				res_hit_q    <= 1'b0;
				mode_q       <= (req.req_type == REQ_QUERY) ? MODE_SEG_LO : MODE_INS_POS;
				if (req.req_type == REQ_QUERY) begin
					res_status_q <= STATUS_OK;
				end else if (count_q == FULL_COUNT) begin
					res_status_q <= STATUS_FULL;
				end else if (req.range_end < req.range_start) begin
					res_status_q <= STATUS_BAD_RANGE;
				end else if (req.ref_id[15]) begin
					res_status_q <= STATUS_BAD_REF;
				end else begin
					res_status_q <= STATUS_OK;
				end
			end
			ST_SEARCH_RD: begin
				if (search_done) begin
					unique case (mode_q)
						MODE_INS_POS: idx_q <= count_q;
						MODE_SEG_LO: begin
							seg_lo_q <= lo_q;
							hi_q     <= count_q;
							mode_q   <= MODE_SEG_HI;
						end
						MODE_SEG_HI: begin
							hi_q   <= lo_q;
							lo_q   <= seg_lo_q;
							mode_q <= MODE_PROBE;
						end
						default: ;
					endcase
				end
			end
			ST_SEARCH_EV: begin
				if (mode_q == MODE_PROBE && !flags.end_lt_first && !flags.start_gt_last) begin
					res_hit_q <= 1'b1;
				end else if (goes_before) begin
					lo_q <= mid + CW'(1);
				end else begin
					hi_q <= mid;
				end
			end
			ST_SHIFT_WR: idx_q <= idx_m1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_PLACE) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == ST_FINISH && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && rsp_free) begin
			rsp_hit_q    <= res_hit_q;
			rsp_status_q <= res_status_q;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.overlap_found = rsp_hit_q;
	assign rsp.status        = rsp_status_q;

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FULL_COUNT)
		else $error("entry count beyond table depth");

	assert property (@(posedge clk) disable iff (!arst_n) accept |=> !req.ready)
		else $error("ready right after taking an item");

	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_SHIFT_WR || state_q == ST_PLACE))
		else $error("table write outside insert");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != STATUS_OK |-> !rsp.overlap_found)
		else $error("hit reported with a reject status");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PLACE |-> count_q < FULL_COUNT)
		else $error("insert into a full table");

endmodule
